[hw/rtl/cpl_pkg.sv]
// ---------------------------------------------------------------------------
// cpl_pkg
// Widths, pipeline depths and shared types of the closest points unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cpl_pkg;

   localparam int QW        = 32;                      // Q16.16 coordinate
   localparam int PRODW     = 2 * QW + 1;              // one term of a dot product
   localparam int DOTW      = PRODW + 2;               // dot product
   localparam int DW3       = 17;                      // multiplier digit, 2nd level
   localparam int MUL3_LAT  = (DOTW + DW3 - 1) / DW3;
   localparam int NUMW      = 2 * DOTW;                // den, ns, nt
   localparam int DW4       = 8;                       // multiplier digit, 3rd level
   localparam int MUL4_LAT  = (QW + DW4 - 1) / DW4;
   localparam int NW        = NUMW + QW;               // coordinate numerator
   localparam int DENW      = 4 * QW;                  // den is below 2^128
   localparam int QB        = QW + 1;                  // quotient bits resolved
   localparam int DIV_LAT   = QB + 2;
   localparam int DEN_STG   = 3 + MUL3_LAT;
   localparam int OUT_STG   = DEN_STG + MUL4_LAT + 2 + DIV_LAT;
   localparam int SIDE1_LEN = DEN_STG;
   localparam int SIDE2_LEN = OUT_STG - DEN_STG;

   localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

   typedef logic [QW-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0] p1;
      coord_type [2:0] d1;
      coord_type [2:0] p2;
      coord_type [2:0] d2;
   } lines_type;

   typedef struct packed {
      coord_type [2:0] p1;
      coord_type [2:0] p2;
      logic            par;
   } ends_type;

endpackage

`default_nettype wire

[hw/rtl/cpl_mul.sv]
// ---------------------------------------------------------------------------
// cpl_mul
// Pipelined signed multiplier, one DW-bit digit of b per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module cpl_mul
   import cpl_pkg::*;
#(
   parameter int WA = DOTW,
   parameter int WB = DOTW,
   parameter int DW = DW3
) (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [WA-1:0]    a,
   input  wire logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0]      p
);

   localparam int NS = (WB + DW - 1) / DW;
   localparam int BP = NS * DW;
   localparam int AW = WA + BP;

   logic signed [WA-1:0] a_ff   [NS];
   logic signed [BP-1:0] b_ff   [NS];
   logic signed [AW-1:0] acc_ff [NS];
   logic signed [BP-1:0] bx;

   assign bx = BP'(b);

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic signed [WA-1:0]   a_src;
      logic signed [BP-1:0]   b_src;
      logic signed [AW-1:0]   acc_src;
      logic signed [DW:0]     dig;
      logic signed [WA+DW:0]  pp;
      logic signed [AW-1:0]   term;

      if (k == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = bx;
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end

      if (k == NS - 1) begin : g_top
         assign dig = $signed({b_src[k*DW+DW-1], b_src[k*DW +: DW]});
      end else begin : g_low
         assign dig = $signed({1'b0, b_src[k*DW +: DW]});
      end

      assign pp   = a_src * dig;
      assign term = AW'(pp) <<< (k * DW);

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_src + term;
            a_ff[k]   <= a_src;
            b_ff[k]   <= b_src;
         end
      end
   end

   assign p = acc_ff[NS-1][WA+WB-1:0];

endmodule

`default_nettype wire

[hw/rtl/cpl_div.sv]
// ---------------------------------------------------------------------------
// cpl_div
// Pipelined restoring divider, one quotient bit per stage, rounding half
// away from zero and saturating to a signed Q16.16 result.
// ---------------------------------------------------------------------------
`default_nettype none

module cpl_div
   import cpl_pkg::*;
#(
   parameter int MAGW  = NW,
   parameter int DVW   = DENW,
   parameter int QBITS = QB
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [MAGW-1:0]   mag,
   input  wire logic [DVW-1:0]    dv,
   input  wire logic              neg,
   output logic      [QW-1:0]     quo
);

   localparam int CW = ((MAGW > DVW + QBITS) ? MAGW : DVW + QBITS) + 1;

   logic [MAGW-1:0]  rem_ff [QBITS+1];
   logic [DVW-1:0]   dv_ff  [QBITS+1];
   logic [QBITS-1:0] q_ff   [QBITS+1];
   logic             neg_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   logic [QW-1:0]    quo_ff;

   logic [CW-1:0]    lim0;
   logic             ovf_in;

   assign lim0   = CW'(dv) << QBITS;
   assign ovf_in = CW'(mag) >= lim0;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= mag;
         dv_ff[0]  <= dv;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar j = 1; j <= QBITS; j++) begin : g_bit
      logic [CW-1:0]    t;
      logic [CW-1:0]    r;
      logic             ge;
      logic [QBITS-1:0] qn;

      assign t  = CW'(dv_ff[j-1]) << (QBITS - j);
      assign r  = CW'(rem_ff[j-1]);
      assign ge = r >= t;
      assign qn = q_ff[j-1] | (QBITS'(ge) << (QBITS - j));

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? MAGW'(r - t) : rem_ff[j-1];
            dv_ff[j]  <= dv_ff[j-1];
            q_ff[j]   <= qn;
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   logic             rnd;
   logic [QBITS:0]   qr;
   logic [QBITS:0]   limit;
   logic             sat;
   logic [QW-1:0]    qlo;
   logic [QW-1:0]    quo_in;

   assign rnd    = {rem_ff[QBITS], 1'b0} >= (MAGW+1)'(dv_ff[QBITS]);
   assign qr     = (QBITS+1)'(q_ff[QBITS]) + (QBITS+1)'(rnd);
   assign limit  = neg_ff[QBITS] ? (QBITS+1)'(SAT_NEG) : (QBITS+1)'(SAT_POS);
   assign sat    = ovf_ff[QBITS] || (qr > limit);
   assign qlo    = qr[QW-1:0];
   assign quo_in = sat ? (neg_ff[QBITS] ? SAT_NEG : SAT_POS)
                       : (neg_ff[QBITS] ? (~qlo + QW'(1)) : qlo);

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/closest_points_two_lines_unit.sv]
// ---------------------------------------------------------------------------
// closest_points_two_lines_unit
// Closest points between two 3D lines given as origin and direction in
// signed Q16.16; parallel or degenerate pairs return both origins.
//
// Usage:
//  - req_* carries one item: two lines. rsp_* carries one item: the two
//    closest points and the parallel flag. Both channels use valid/stall.
//  - One item may be accepted every cycle while req_stall is low. The path
//    runs through the input register, dot products and denominator products,
//    then coordinate numerator products, sum and sign, and a 35-stage
//    divider whose bit stages each resolve one quotient bit.
//  - The whole pipeline advances together. While a result waits at the
//    output under rsp_stall, req_stall is raised and nothing moves, so no
//    item is lost or repeated.
//  - Synchronous reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module closest_points_two_lines_unit
   import cpl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [31:0]   req_ray1_origin_x,
   input  wire logic [31:0]   req_ray1_origin_y,
   input  wire logic [31:0]   req_ray1_origin_z,
   input  wire logic [31:0]   req_ray1_dir_x,
   input  wire logic [31:0]   req_ray1_dir_y,
   input  wire logic [31:0]   req_ray1_dir_z,
   input  wire logic [31:0]   req_ray2_origin_x,
   input  wire logic [31:0]   req_ray2_origin_y,
   input  wire logic [31:0]   req_ray2_origin_z,
   input  wire logic [31:0]   req_ray2_dir_x,
   input  wire logic [31:0]   req_ray2_dir_y,
   input  wire logic [31:0]   req_ray2_dir_z,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [31:0]        rsp_near1_x,
   output logic [31:0]        rsp_near1_y,
   output logic [31:0]        rsp_near1_z,
   output logic [31:0]        rsp_near2_x,
   output logic [31:0]        rsp_near2_y,
   output logic [31:0]        rsp_near2_z,
   output logic               rsp_parallel_flag
);

   logic adv;
   logic vld_ff [OUT_STG+1];

   assign adv       = !vld_ff[OUT_STG] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[OUT_STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= OUT_STG; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= OUT_STG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // input stage
   lines_type        s0_in, s0_ff;
   logic [2:0][QW:0] w0_in, w0_ff;

   assign s0_in.p1 = {req_ray1_origin_z, req_ray1_origin_y, req_ray1_origin_x};
   assign s0_in.d1 = {req_ray1_dir_z, req_ray1_dir_y, req_ray1_dir_x};
   assign s0_in.p2 = {req_ray2_origin_z, req_ray2_origin_y, req_ray2_origin_x};
   assign s0_in.d2 = {req_ray2_dir_z, req_ray2_dir_y, req_ray2_dir_x};

   for (genvar i = 0; i < 3; i++) begin : g_w0
      assign w0_in[i] = {s0_in.p1[i][QW-1], s0_in.p1[i]}
                      - {s0_in.p2[i][QW-1], s0_in.p2[i]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         w0_ff <= w0_in;
      end
   end

   // dot product terms and sums
   logic signed [PRODW-1:0] pa_w [3], pb_w [3], pc_w [3], pd_w [3], pe_w [3];
   logic signed [PRODW-1:0] pa_ff [3], pb_ff [3], pc_ff [3], pd_ff [3], pe_ff [3];
   logic signed [DOTW-1:0]  a_ff, b_ff, c_ff, d_ff, e_ff;

   for (genvar i = 0; i < 3; i++) begin : g_term
      assign pa_w[i] = $signed(s0_ff.d1[i]) * $signed(s0_ff.d1[i]);
      assign pb_w[i] = $signed(s0_ff.d1[i]) * $signed(s0_ff.d2[i]);
      assign pc_w[i] = $signed(s0_ff.d2[i]) * $signed(s0_ff.d2[i]);
      assign pd_w[i] = $signed(s0_ff.d1[i]) * $signed(w0_ff[i]);
      assign pe_w[i] = $signed(s0_ff.d2[i]) * $signed(w0_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= pa_w[i];
            pb_ff[i] <= pb_w[i];
            pc_ff[i] <= pc_w[i];
            pd_ff[i] <= pd_w[i];
            pe_ff[i] <= pe_w[i];
         end
         a_ff <= DOTW'(pa_ff[0]) + DOTW'(pa_ff[1]) + DOTW'(pa_ff[2]);
         b_ff <= DOTW'(pb_ff[0]) + DOTW'(pb_ff[1]) + DOTW'(pb_ff[2]);
         c_ff <= DOTW'(pc_ff[0]) + DOTW'(pc_ff[1]) + DOTW'(pc_ff[2]);
         d_ff <= DOTW'(pd_ff[0]) + DOTW'(pd_ff[1]) + DOTW'(pd_ff[2]);
         e_ff <= DOTW'(pe_ff[0]) + DOTW'(pe_ff[1]) + DOTW'(pe_ff[2]);
      end
   end

   // denominator and line parameter numerators
   logic signed [NUMW-1:0] ac_w, bb_w, be_w, cd_w, ae_w, bd_w;
   logic signed [NUMW-1:0] den_ff, ns_ff, nt_ff;
   logic                   par_ff;

   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_ac (
      .clock(clock), .en(adv), .a(a_ff), .b(c_ff), .p(ac_w));
   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_bb (
      .clock(clock), .en(adv), .a(b_ff), .b(b_ff), .p(bb_w));
   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_be (
      .clock(clock), .en(adv), .a(b_ff), .b(e_ff), .p(be_w));
   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_cd (
      .clock(clock), .en(adv), .a(c_ff), .b(d_ff), .p(cd_w));
   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_ae (
      .clock(clock), .en(adv), .a(a_ff), .b(e_ff), .p(ae_w));
   cpl_mul #(.WA(DOTW), .WB(DOTW), .DW(DW3)) u_mul_bd (
      .clock(clock), .en(adv), .a(b_ff), .b(d_ff), .p(bd_w));

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= ac_w - bb_w;
         ns_ff  <= be_w - cd_w;
         nt_ff  <= ae_w - bd_w;
         par_ff <= (ac_w == bb_w);
      end
   end

   // line data alongside the dot product path
   lines_type side1_ff [SIDE1_LEN];

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff[0] <= s0_ff;
         for (int i = 1; i < SIDE1_LEN; i++) side1_ff[i] <= side1_ff[i-1];
      end
   end

   // coordinate numerators: p*den + dir*num
   logic signed [NW-1:0] m1p_w [3], m1d_w [3], m2p_w [3], m2d_w [3];
   logic signed [NW-1:0] n_ff [6];
   logic [NUMW-1:0]      denq_ff [MUL4_LAT+1];

   for (genvar i = 0; i < 3; i++) begin : g_num
      cpl_mul #(.WA(NUMW), .WB(QW), .DW(DW4)) u_mul_1p (
         .clock(clock), .en(adv), .a(den_ff),
         .b($signed(side1_ff[SIDE1_LEN-1].p1[i])), .p(m1p_w[i]));
      cpl_mul #(.WA(NUMW), .WB(QW), .DW(DW4)) u_mul_1d (
         .clock(clock), .en(adv), .a(ns_ff),
         .b($signed(side1_ff[SIDE1_LEN-1].d1[i])), .p(m1d_w[i]));
      cpl_mul #(.WA(NUMW), .WB(QW), .DW(DW4)) u_mul_2p (
         .clock(clock), .en(adv), .a(den_ff),
         .b($signed(side1_ff[SIDE1_LEN-1].p2[i])), .p(m2p_w[i]));
      cpl_mul #(.WA(NUMW), .WB(QW), .DW(DW4)) u_mul_2d (
         .clock(clock), .en(adv), .a(nt_ff),
         .b($signed(side1_ff[SIDE1_LEN-1].d2[i])), .p(m2d_w[i]));
   end

   logic [NW-1:0]   mag_ff [6];
   logic            neg_ff [6];
   logic [DENW-1:0] dv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         denq_ff[0] <= den_ff;
         for (int i = 1; i <= MUL4_LAT; i++) denq_ff[i] <= denq_ff[i-1];
         for (int i = 0; i < 3; i++) begin
            n_ff[i]   <= m1p_w[i] + m1d_w[i];
            n_ff[3+i] <= m2p_w[i] + m2d_w[i];
         end
         for (int i = 0; i < 6; i++) begin
            neg_ff[i] <= n_ff[i][NW-1];
            mag_ff[i] <= n_ff[i][NW-1] ? (~n_ff[i] + NW'(1)) : n_ff[i];
         end
         dv_ff <= denq_ff[MUL4_LAT][DENW-1:0];
      end
   end

   // division
   logic [QW-1:0] quo_w [6];

   for (genvar i = 0; i < 6; i++) begin : g_div
      cpl_div #(.MAGW(NW), .DVW(DENW), .QBITS(QB)) u_div (
         .clock(clock), .en(adv), .mag(mag_ff[i]), .dv(dv_ff), .neg(neg_ff[i]),
         .quo(quo_w[i]));
   end

   // origins and parallel flag alongside the numerator products and the divider
   ends_type side2_ff [SIDE2_LEN];
   ends_type side2_in;

   assign side2_in.p1  = side1_ff[SIDE1_LEN-1].p1;
   assign side2_in.p2  = side1_ff[SIDE1_LEN-1].p2;
   assign side2_in.par = par_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= side2_in;
         for (int i = 1; i < SIDE2_LEN; i++) side2_ff[i] <= side2_ff[i-1];
      end
   end

   ends_type ends_out;

   assign ends_out          = side2_ff[SIDE2_LEN-1];
   assign rsp_parallel_flag = ends_out.par;
   assign rsp_near1_x       = ends_out.par ? ends_out.p1[0] : quo_w[0];
   assign rsp_near1_y       = ends_out.par ? ends_out.p1[1] : quo_w[1];
   assign rsp_near1_z       = ends_out.par ? ends_out.p1[2] : quo_w[2];
   assign rsp_near2_x       = ends_out.par ? ends_out.p2[0] : quo_w[3];
   assign rsp_near2_y       = ends_out.par ? ends_out.p2[1] : quo_w[4];
   assign rsp_near2_z       = ends_out.par ? ends_out.p2[2] : quo_w[5];

`ifndef SYNTH
   a_den_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEN_STG] |-> den_ff[NUMW-1:DENW] == '0)
      else $error("denominator negative or beyond divider width");

   a_par_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEN_STG] |-> (par_ff == (den_ff == '0)))
      else $error("parallel flag disagrees with denominator");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv && vld_ff[DEN_STG] |=> $stable(den_ff) && vld_ff[DEN_STG])
      else $error("pipeline moved while output stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

[test/closest_points_two_lines_unit_test.sv]
// ---------------------------------------------------------------------------
// closest_points_two_lines_unit_test
// Self-checking bench for the closest points unit. A queue of line pairs
// feeds a clocked driver. Each accepted item is predicted with exact wide
// integer arithmetic: rounding half away from zero, saturation, and the
// parallel fallback. A clocked monitor compares every result with the oldest
// prediction. Random idling on both sides runs in phases, and one long
// receiver hold-off lets the pipeline fill up.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module closest_points_two_lines_unit_test
   import cpl_pkg::*;
;

   typedef logic signed [191:0] wide_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_parallel_flag;
   coord_type  rsp_near1_x, rsp_near1_y, rsp_near1_z;
   coord_type  rsp_near2_x, rsp_near2_y, rsp_near2_z;
   lines_type  held = '0;

   lines_type  pending_pairs[$];
   ends_type   expected_points[$];
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   logic       hold_on = 1'b0;
   int         errors = 0;
   int         pairs_sent = 0;
   int         points_seen = 0;
   int         parallel_seen = 0;

   closest_points_two_lines_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_ray1_origin_x(held.p1[0]), .req_ray1_origin_y(held.p1[1]),
      .req_ray1_origin_z(held.p1[2]),
      .req_ray1_dir_x(held.d1[0]), .req_ray1_dir_y(held.d1[1]),
      .req_ray1_dir_z(held.d1[2]),
      .req_ray2_origin_x(held.p2[0]), .req_ray2_origin_y(held.p2[1]),
      .req_ray2_origin_z(held.p2[2]),
      .req_ray2_dir_x(held.d2[0]), .req_ray2_dir_y(held.d2[1]),
      .req_ray2_dir_z(held.d2[2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_near1_x(rsp_near1_x), .rsp_near1_y(rsp_near1_y),
      .rsp_near1_z(rsp_near1_z),
      .rsp_near2_x(rsp_near2_x), .rsp_near2_y(rsp_near2_y),
      .rsp_near2_z(rsp_near2_z),
      .rsp_parallel_flag(rsp_parallel_flag)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic wide_type widen(coord_type v);
      return wide_type'($signed(v));
   endfunction

   // (p*den + dir*num) / den, nearest, ties away from zero, saturated
   function automatic coord_type place_coord(wide_type p, wide_type dir,
                                             wide_type num, wide_type den);
      wide_type n, mag, q, r;
      logic     neg;
      n = p * den + dir * num;
      neg = n < 0;
      mag = neg ? -n : n;
      q = mag / den;
      r = mag - q * den;
      if (2 * r >= den) q = q + 1;
      if (neg) return (q > 192'sh80000000) ? SAT_NEG : coord_type'(-q);
      return (q > 192'sh7FFFFFFF) ? SAT_POS : coord_type'(q);
   endfunction

   function automatic ends_type nearest_points(lines_type l);
      wide_type p1[3], d1[3], p2[3], d2[3], w[3];
      wide_type a, b, c, d, e, den, ns, nt;
      ends_type r;
      for (int i = 0; i < 3; i++) begin
         p1[i] = widen(l.p1[i]);
         d1[i] = widen(l.d1[i]);
         p2[i] = widen(l.p2[i]);
         d2[i] = widen(l.d2[i]);
         w[i]  = p1[i] - p2[i];
      end
      a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
      b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
      c = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
      d = d1[0]*w[0] + d1[1]*w[1] + d1[2]*w[2];
      e = d2[0]*w[0] + d2[1]*w[1] + d2[2]*w[2];
      den = a * c - b * b;
      if (den == 0) begin
         r.p1 = l.p1;
         r.p2 = l.p2;
         r.par = 1'b1;
         return r;
      end
      ns = b * e - c * d;
      nt = a * e - b * d;
      for (int i = 0; i < 3; i++) begin
         r.p1[i] = place_coord(p1[i], d1[i], ns, den);
         r.p2[i] = place_coord(p2[i], d2[i], nt, den);
      end
      r.par = 1'b0;
      return r;
   endfunction

   function automatic coord_type rand_coord();
      unique case ($urandom_range(5))
         0: return $urandom;
         1: return coord_type'($signed($urandom_range(2097152)) - 1048576);
         2: return coord_type'(($urandom_range(64) - 32) <<< 16);
         3: return $urandom_range(1) ? SAT_POS : SAT_NEG;
         4: return $urandom_range(3) == 0 ? '0 : coord_type'($urandom_range(255));
         default: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   function automatic lines_type rand_pair();
      lines_type l;
      int        k;
      for (int i = 0; i < 3; i++) begin
         l.p1[i] = rand_coord();
         l.d1[i] = rand_coord();
         l.p2[i] = rand_coord();
         l.d2[i] = rand_coord();
      end
      k = $urandom_range(9);
      if (k == 0) begin
         l.d2 = l.d1;                      // parallel
      end else if (k == 1) begin
         for (int i = 0; i < 3; i++) l.d2[i] = -l.d1[i];
      end else if (k == 2) begin
         if ($urandom_range(1)) l.d1 = '0; else l.d2 = '0;
      end else if (k == 3) begin
         for (int i = 0; i < 3; i++) l.d2[i] = l.d1[i] <<< 1;
      end
      return l;
   endfunction

   task automatic add_pair(coord_type p1x, p1y, p1z, d1x, d1y, d1z,
                           coord_type p2x, p2y, p2z, d2x, d2y, d2z);
      lines_type l;
      l.p1 = {p1z, p1y, p1x};
      l.d1 = {d1z, d1y, d1x};
      l.p2 = {p2z, p2y, p2x};
      l.d2 = {d2z, d2y, d2x};
      pending_pairs.push_back(l);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_points.push_back(nearest_points(held));
            pairs_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               held <= pending_pairs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ends_type x;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            points_seen++;
            if (expected_points.size() == 0) begin
               $error("result item with no item outstanding");
               errors++;
            end else begin
               x = expected_points.pop_front();
               if (x.par) parallel_seen++;
               if (rsp_near1_x !== x.p1[0]) begin
                  $error("near1_x exp %h got %h", x.p1[0], rsp_near1_x); errors++;
               end
               if (rsp_near1_y !== x.p1[1]) begin
                  $error("near1_y exp %h got %h", x.p1[1], rsp_near1_y); errors++;
               end
               if (rsp_near1_z !== x.p1[2]) begin
                  $error("near1_z exp %h got %h", x.p1[2], rsp_near1_z); errors++;
               end
               if (rsp_near2_x !== x.p2[0]) begin
                  $error("near2_x exp %h got %h", x.p2[0], rsp_near2_x); errors++;
               end
               if (rsp_near2_y !== x.p2[1]) begin
                  $error("near2_y exp %h got %h", x.p2[1], rsp_near2_y); errors++;
               end
               if (rsp_near2_z !== x.p2[2]) begin
                  $error("near2_z exp %h got %h", x.p2[2], rsp_near2_z); errors++;
               end
               if (rsp_parallel_flag !== x.par) begin
                  $error("parallel_flag exp %b got %b", x.par, rsp_parallel_flag); errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      while (pending_pairs.size() != 0 || req_valid || expected_points.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int        sender[4];
      int        receiver[4];
      coord_type one;
      sender   = '{0, 87, 0, 16};
      receiver = '{0, 0, 87, 16};
      one      = 32'h0001_0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      add_pair('0, '0, '0, one, '0, '0, '0, one, one, '0, one, '0);
      add_pair(one, one, one, '0, '0, one, -one, -one, -one, one, '0, '0);
      add_pair('0, '0, '0, one, one, '0, one, '0, '0, one, one, '0);
      add_pair('0, '0, '0, one, '0, '0, '0, one, '0, -one, '0, '0);
      add_pair('0, '0, '0, '0, '0, '0, one, one, one, one, '0, '0);
      add_pair(SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS,
               SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
      add_pair(SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_POS,
               SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_POS, SAT_NEG);
      add_pair(SAT_POS, '0, '0, 32'd1, '0, '0, SAT_NEG, SAT_POS, '0, '0, '0, 32'd1);
      add_pair(SAT_NEG, SAT_NEG, '0, 32'd1, 32'd1, '0, SAT_POS, '0, SAT_POS, 32'd1, 32'd2, '0);
      add_pair('0, '0, '0, 32'd1, '0, '0, 32'd1, 32'd1, '0, 32'd1, 32'd1, '0);
      add_pair('1, '1, '1, 32'd3, 32'd1, '0, 32'd2, '1, 32'd5, '0, 32'd7, 32'd1);
      add_pair(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, '0, '0, SAT_POS, SAT_POS, SAT_POS,
               '0, SAT_NEG, '0);
      add_pair('0, '0, '0, one, '0, '0, one <<< 4, one, '0, one, 32'd1, '0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct <= sender[ph];
         stall_pct <= receiver[ph];
         for (int i = 0; i < 185; i++) pending_pairs.push_back(rand_pair());
         if (ph == 0) begin
            hold_on <= 1'b1;
            repeat (200) @(posedge clock);
            hold_on <= 1'b0;
         end
         drain();
      end
      send_idle_pct <= 0;
      stall_pct <= 0;
      repeat (60) @(posedge clock);

      $display("%0d line pairs sent, %0d results checked, %0d of them parallel",
               pairs_sent, points_seen, parallel_seen);
      $display("idle phases: none, sender 87%%, receiver 87%%, both 16%%; one long hold-off");
      if (errors == 0 && expected_points.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cpl_pkg.sv
hw/rtl/cpl_mul.sv
hw/rtl/cpl_div.sv
hw/rtl/closest_points_two_lines_unit.sv
test/closest_points_two_lines_unit_test.sv
